### rtl/lqs_pkg.sv
// Shared types and constants for the link quality scorer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package lqs_pkg;

  // Scores are counts of 1/256 point.
  localparam logic [14:0] SCORE_100 = 15'd25600;
  localparam logic [14:0] SCORE_90  = 15'd23040;
  localparam logic [14:0] SCORE_80  = 15'd20480;
  localparam logic [14:0] SCORE_75  = 15'd19200;
  localparam logic [14:0] SCORE_60  = 15'd15360;
  localparam logic [14:0] SCORE_50  = 15'd12800;
  localparam logic [14:0] SCORE_30  = 15'd7680;
  localparam logic [14:0] SCORE_20  = 15'd5120;
  localparam logic [14:0] SCORE_10  = 15'd2560;

  localparam int RSSI_EXCELLENT_DBM = -50;
  localparam int RSSI_GOOD_DBM      = -60;
  localparam int RSSI_FAIR_DBM      = -70;

  localparam int unsigned RTT_TAIL_US = 80000;
  localparam int unsigned LOSS_TAIL   = 250;

  localparam logic [2:0] LEVEL_UNKNOWN = 3'd4;

  // Number of steps of the shared divider and of the traffic multiplier.
  localparam int unsigned ITER_STEPS = 16;

  typedef enum logic [2:0] {
    SEL_RTT,
    SEL_LOSS,
    SEL_RSSI,
    SEL_TRF,
    SEL_TOT
  } sel_e;

  typedef enum logic [2:0] {
    CFG_RTT_EXCELLENT,
    CFG_RTT_GOOD,
    CFG_RTT_FAIR,
    CFG_LOSS_EXCELLENT,
    CFG_LOSS_GOOD,
    CFG_LOSS_FAIR,
    CFG_MIN_FLOWS
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_INIT,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic store;
    logic finish;
    sel_e sel;
  } lqs_cmd_t;

  typedef struct packed {
    logic out_busy;
  } lqs_stat_t;

endpackage

`default_nettype wire

### rtl/lqs_divider.sv
// Iterative restoring divider with rounding to nearest, one quotient bit a cycle while step_i is set.
// Imports lqs_pkg; the step count is set by the sequencer.
`default_nettype none

module lqs_divider
  import lqs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        init_i,
  input  wire logic        step_i,
  input  wire logic [61:0] mag_i,
  input  wire logic [47:0] den_i,
  output logic      [15:0] quot_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] dsh_q, dsh_d;
  logic [15:0] quot_q, quot_d;

  // Rounding is folded in: quotient of (2*mag + den) by 2*den. The quotient is
  // known to fit 16 bits, so the divisor starts shifted up by 15 places.
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (init_i) begin
      rem_d  = {1'b0, mag_i, 1'b0} + {16'b0, den_i};
      dsh_d  = {den_i, 16'b0};
      quot_d = '0;
    end else if (step_i) begin
      if (rem_q >= dsh_q) begin
        rem_d  = rem_q - dsh_q;
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        quot_d = {quot_q[14:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

### rtl/lqs_ctrl.sv
// Sequencer for the link quality scorer: steps the datapath through the
// traffic multiply and five divides. Depends on lqs_pkg.
`default_nettype none

module lqs_ctrl
  import lqs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lqs_stat_t stat_i,
  output lqs_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  sel_e        sel_q, sel_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        last_step;

  assign last_step = (cnt_q == 4'(ITER_STEPS - 1));

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP:     state_d = ST_MUL_INIT;
      ST_MUL_INIT: begin
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 4'd1;
        if (last_step) begin
          sel_d   = SEL_RTT;
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 4'd1;
        if (last_step) state_d = ST_STORE;
      end
      ST_STORE: begin
        priority case (sel_q)
          SEL_RTT:  sel_d = SEL_LOSS;
          SEL_LOSS: sel_d = SEL_RSSI;
          SEL_RSSI: sel_d = SEL_TRF;
          SEL_TRF:  sel_d = SEL_TOT;
          default:  sel_d = sel_q;
        endcase
        state_d = (sel_q == SEL_TOT) ? ST_FINISH : ST_DIV_INIT;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:     cmd_o.prep     = 1'b1;
      ST_MUL_INIT: cmd_o.mul_init = 1'b1;
      ST_MUL:      cmd_o.mul_step = 1'b1;
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_STORE:    cmd_o.store    = 1'b1;
      ST_FINISH:   cmd_o.finish   = !stat_i.out_busy;
      default:     cmd_o.load     = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= SEL_RTT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/lqs_datapath.sv
// Datapath of the link quality scorer: configuration, input and score
// registers, segment setup, traffic multiplier and output register.
// Depends on lqs_pkg and lqs_divider.
`default_nettype none

module lqs_datapath
  import lqs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lqs_cmd_t          cmd_i,
  output lqs_stat_t              stat_o,
  input  wire logic              cfg_we_i,
  input  wire logic        [2:0] cfg_index_i,
  input  wire logic       [23:0] cfg_data_i,
  input  wire logic              rtt_valid_i,
  input  wire logic       [23:0] rtt_us_i,
  input  wire logic              loss_valid_i,
  input  wire logic       [13:0] loss_rate_i,
  input  wire logic              rssi_valid_i,
  input  wire logic signed [7:0] rssi_dbm_i,
  input  wire logic       [15:0] flow_count_i,
  input  wire logic       [31:0] bit_rate_i,
  input  wire logic       [31:0] packet_rate_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic            [14:0] total_score_o,
  output logic             [1:0] level_o,
  output logic                   changed_o,
  output logic            [15:0] change_count_o,
  output logic            [14:0] rtt_sub_o,
  output logic            [14:0] loss_sub_o,
  output logic            [14:0] rssi_sub_o,
  output logic            [14:0] traffic_sub_o,
  output logic             [3:0] issue_bits_o,
  output logic             [1:0] overall_issue_o
);

  typedef struct packed {
    logic        bypass;
    logic [14:0] direct;
    logic [14:0] base;
    logic        neg;
    logic [39:0] mag;
    logic [25:0] den;
  } seg_t;

  localparam logic signed [26:0] R_EX   = 27'(RSSI_EXCELLENT_DBM);
  localparam logic signed [26:0] R_GD   = 27'(RSSI_GOOD_DBM);
  localparam logic signed [26:0] R_FR   = 27'(RSSI_FAIR_DBM);
  localparam logic signed [26:0] R_TAIL = 27'(RSSI_FAIR_DBM - 25);

  function automatic seg_t seg_setup(input logic signed [26:0] v, input logic signed [26:0] lv,
                                     input logic signed [26:0] rv, input logic [14:0] ls,
                                     input logic [14:0] rs);
    seg_t        s;
    logic [13:0] dl;
    logic [25:0] dv;
    s  = '0;
    dl = (rs < ls) ? 14'(ls - rs) : 14'(rs - ls);
    dv = 26'(v - lv);
    s.base = ls;
    if (rv <= lv || v <= lv) begin
      s.bypass = 1'b1;
      s.direct = ls;
    end else if (v >= rv) begin
      s.bypass = 1'b1;
      s.direct = rs;
    end else begin
      s.neg = (rs < ls);
      s.den = 26'(rv - lv);
      s.mag = {14'b0, dv} * {26'b0, dl};
    end
    return s;
  endfunction

  function automatic seg_t three_step(input logic signed [26:0] v, input logic signed [26:0] ex,
                                      input logic signed [26:0] gd, input logic signed [26:0] fr,
                                      input logic signed [26:0] tail, input logic [14:0] floor_s);
    seg_t s;
    s = '0;
    if (v <= ex) begin
      s.bypass = 1'b1;
      s.direct = SCORE_100;
    end else if (v <= gd) begin
      s = seg_setup(v, ex, gd, SCORE_100, SCORE_80);
    end else if (v <= fr) begin
      s = seg_setup(v, gd, fr, SCORE_80, SCORE_60);
    end else begin
      s = seg_setup(v, fr, fr + tail, SCORE_60, floor_s);
    end
    return s;
  endfunction

  // Configuration registers.
  logic [23:0] rtt_ex_q, rtt_gd_q, rtt_fr_q;
  logic [13:0] loss_ex_q, loss_gd_q, loss_fr_q;
  logic [15:0] min_flows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_ex_q    <= 24'd50000;
      rtt_gd_q    <= 24'd100000;
      rtt_fr_q    <= 24'd200000;
      loss_ex_q   <= 14'd100;
      loss_gd_q   <= 14'd300;
      loss_fr_q   <= 14'd500;
      min_flows_q <= 16'd10;
    end else if (cfg_we_i) begin
      priority case (cfg_index_i)
        CFG_RTT_EXCELLENT:  rtt_ex_q    <= cfg_data_i;
        CFG_RTT_GOOD:       rtt_gd_q    <= cfg_data_i;
        CFG_RTT_FAIR:       rtt_fr_q    <= cfg_data_i;
        CFG_LOSS_EXCELLENT: loss_ex_q   <= cfg_data_i[13:0];
        CFG_LOSS_GOOD:      loss_gd_q   <= cfg_data_i[13:0];
        CFG_LOSS_FAIR:      loss_fr_q   <= cfg_data_i[13:0];
        CFG_MIN_FLOWS:      min_flows_q <= cfg_data_i[15:0];
        default:            min_flows_q <= min_flows_q;
      endcase
    end
  end

  // Input item registers.
  logic              rtt_v_q, loss_v_q, rssi_v_q;
  logic       [23:0] rtt_q;
  logic       [13:0] loss_q;
  logic signed [7:0] rssi_q;
  logic       [15:0] flows_q;
  logic       [31:0] bps_q, pps_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rtt_v_q  <= rtt_valid_i;
      rtt_q    <= rtt_us_i;
      loss_v_q <= loss_valid_i;
      loss_q   <= loss_rate_i;
      rssi_v_q <= rssi_valid_i;
      rssi_q   <= rssi_dbm_i;
      flows_q  <= flow_count_i;
      bps_q    <= bit_rate_i;
      pps_q    <= packet_rate_i;
    end
  end

  logic signed [26:0] rssi_w;
  logic               trf_ok;
  logic        [39:0] t200;
  logic        [41:0] t800;

  assign rssi_w = $signed({{19{rssi_q[7]}}, rssi_q});
  assign trf_ok = (flows_q != '0) && (bps_q != '0) && (pps_q != '0);
  assign t200   = {8'b0, pps_q} * 40'd200;
  assign t800   = {10'b0, pps_q} * 42'd800;

  // Traffic preparation: clamped flow count, clamped rate excess and the
  // divisor max(min_flows, 1) * packet_rate.
  logic [15:0] m_w, fcl_w;
  logic [41:0] n_w;
  logic [15:0] fcl_q;
  logic [41:0] n_q;
  logic [47:0] den_q;

  always_comb begin
    m_w   = (min_flows_q == '0) ? 16'd1 : min_flows_q;
    fcl_w = (flows_q > m_w) ? m_w : flows_q;
    if ({8'b0, bps_q} <= t200) begin
      n_w = '0;
    end else begin
      n_w = 42'({8'b0, bps_q} - t200);
    end
    if (n_w > t800) n_w = t800;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      fcl_q <= fcl_w;
      n_q   <= n_w;
      den_q <= {32'b0, m_w} * {16'b0, pps_q};
    end
  end

  // Shift-and-add multiply of the clamped flow count by |32n - 12800*pps|.
  logic [46:0] p32, p12800;
  logic [61:0] acc_q, mcand_q;
  logic [15:0] mplier_q;
  logic        tneg_q;

  assign p32    = {n_q, 5'b0};
  assign p12800 = {15'b0, pps_q} * 47'd12800;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init) begin
      acc_q    <= '0;
      mplier_q <= fcl_q;
      tneg_q   <= (p32 < p12800);
      mcand_q  <= (p32 < p12800) ? {15'b0, p12800 - p32} : {15'b0, p32 - p12800};
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[60:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[15:1]};
    end
  end

  // Segment setup for the metric being worked on.
  logic [14:0] rs_q, ls_q, ss_q, ts_q, total_q;
  seg_t        seg;
  seg_t        neutral;
  logic [18:0] sum;

  always_comb begin
    neutral        = '0;
    neutral.bypass = 1'b1;
    neutral.direct = SCORE_50;
    unique case (cmd_i.sel)
      SEL_RTT:  seg = rtt_v_q
          ? three_step({3'b0, rtt_q}, {3'b0, rtt_ex_q}, {3'b0, rtt_gd_q}, {3'b0, rtt_fr_q},
                       27'(RTT_TAIL_US), SCORE_20)
          : neutral;
      SEL_LOSS: seg = loss_v_q
          ? three_step({13'b0, loss_q}, {13'b0, loss_ex_q}, {13'b0, loss_gd_q},
                       {13'b0, loss_fr_q}, 27'(LOSS_TAIL), SCORE_10)
          : neutral;
      SEL_RSSI: begin
        if (!rssi_v_q) seg = neutral;
        else if (rssi_w >= R_EX) begin
          seg        = neutral;
          seg.direct = SCORE_100;
        end else if (rssi_w >= R_GD) seg = seg_setup(rssi_w, R_GD, R_EX, SCORE_80, SCORE_100);
        else if (rssi_w >= R_FR) seg = seg_setup(rssi_w, R_FR, R_GD, SCORE_60, SCORE_80);
        else seg = seg_setup(rssi_w, R_TAIL, R_FR, SCORE_10, SCORE_60);
      end
      default:  seg = neutral;
    endcase
  end

  assign sum = 19'd3 * {4'b0, rs_q} + 19'd3 * {4'b0, ls_q}
             + 19'd2 * {4'b0, ss_q} + 19'd2 * {4'b0, ts_q};

  logic [61:0] div_mag;
  logic [47:0] div_den;
  logic [15:0] quot;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_TRF: begin
        div_mag = acc_q;
        div_den = den_q;
      end
      SEL_TOT: begin
        div_mag = {43'b0, sum};
        div_den = 48'd10;
      end
      default: begin
        div_mag = {22'b0, seg.mag};
        div_den = {22'b0, seg.den};
      end
    endcase
  end

  lqs_divider u_div (
    .clk_i  (clk_i),
    .init_i (cmd_i.div_init),
    .step_i (cmd_i.div_step),
    .mag_i  (div_mag),
    .den_i  (div_den),
    .quot_o (quot)
  );

  logic [14:0] seg_res, trf_res;

  always_comb begin
    if (seg.bypass) seg_res = seg.direct;
    else if (seg.neg) seg_res = seg.base - quot[14:0];
    else seg_res = seg.base + quot[14:0];

    if (!trf_ok) trf_res = SCORE_50;
    else if (tneg_q) trf_res = (quot >= {1'b0, SCORE_50}) ? 15'd0 : SCORE_50 - quot[14:0];
    else trf_res = (quot >= {1'b0, SCORE_50}) ? SCORE_100 : SCORE_50 + quot[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      unique case (cmd_i.sel)
        SEL_RTT:  rs_q    <= seg_res;
        SEL_LOSS: ls_q    <= seg_res;
        SEL_RSSI: ss_q    <= seg_res;
        SEL_TRF:  ts_q    <= trf_res;
        default:  total_q <= quot[14:0];
      endcase
    end
  end

  // Level, issues and change detection.
  logic [2:0]  prev_level_q;
  logic [14:0] prev_score_q;
  logic [15:0] count_q, count_d;
  logic [1:0]  level, overall;
  logic [3:0]  issues;
  logic [14:0] diff;
  logic        changed;

  always_comb begin
    if (total_q >= SCORE_90) level = 2'd3;
    else if (total_q >= SCORE_75) level = 2'd2;
    else if (total_q >= SCORE_50) level = 2'd1;
    else level = 2'd0;

    if (total_q < SCORE_30) overall = 2'd2;
    else if (total_q < SCORE_50) overall = 2'd1;
    else overall = 2'd0;

    issues[0] = rtt_v_q && (rtt_q > rtt_fr_q);
    issues[1] = loss_v_q && (loss_q > loss_fr_q);
    issues[2] = rssi_v_q && (rssi_w < R_FR);
    issues[3] = trf_ok && ({8'b0, bps_q} < t200);

    diff    = (total_q > prev_score_q) ? total_q - prev_score_q : prev_score_q - total_q;
    changed = ({1'b0, level} != prev_level_q) || (diff > SCORE_10);
    count_d = changed ? count_q + 16'd1 : count_q;
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= LEVEL_UNKNOWN;
      prev_score_q <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        prev_level_q <= {1'b0, level};
        prev_score_q <= total_q;
        count_q      <= count_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      total_score_o   <= total_q;
      level_o         <= level;
      changed_o       <= changed;
      change_count_o  <= count_d;
      rtt_sub_o       <= rs_q;
      loss_sub_o      <= ls_q;
      rssi_sub_o      <= ss_q;
      traffic_sub_o   <= ts_q;
      issue_bits_o    <= issues;
      overall_issue_o <= overall;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

### rtl/link_quality_scorer.sv
// Top level of the link quality scorer: sequencer plus datapath.
// Depends on lqs_pkg, lqs_ctrl, lqs_datapath and lqs_divider.
`default_nettype none

// Scores one link snapshot per input beat and returns one result beat. An
// item goes from acceptance to its result through a prepare step and a
// 16-step shift-add multiply with its setup step for the traffic term, then
// five runs of the shared 16-step divider (RTT, loss, signal and traffic
// sub-scores, then the weighted total), each with a setup and a store step,
// and a final step that loads the output register. One item is worked on at
// a time, so a new input beat is not taken before the last one is through;
// the next one is taken as soon as the sequencer is idle, while the previous
// result may still wait in the output register. The final step stalls for as
// long as an earlier result is still waiting. Configuration writes are always
// taken and must only be made while no item is in flight.
module link_quality_scorer
  import lqs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic        [2:0] cfg_index_i,
  input  wire logic       [23:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              rtt_valid_i,
  input  wire logic       [23:0] rtt_us_i,
  input  wire logic              loss_valid_i,
  input  wire logic       [13:0] loss_rate_i,
  input  wire logic              rssi_valid_i,
  input  wire logic signed [7:0] rssi_dbm_i,
  input  wire logic       [15:0] flow_count_i,
  input  wire logic       [31:0] bit_rate_i,
  input  wire logic       [31:0] packet_rate_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic            [14:0] total_score_o,
  output logic             [1:0] level_o,
  output logic                   changed_o,
  output logic            [15:0] change_count_o,
  output logic            [14:0] rtt_sub_o,
  output logic            [14:0] loss_sub_o,
  output logic            [14:0] rssi_sub_o,
  output logic            [14:0] traffic_sub_o,
  output logic             [3:0] issue_bits_o,
  output logic             [1:0] overall_issue_o
);

  lqs_cmd_t  cmd;
  lqs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lqs_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rtt_valid_i     (rtt_valid_i),
    .rtt_us_i        (rtt_us_i),
    .loss_valid_i    (loss_valid_i),
    .loss_rate_i     (loss_rate_i),
    .rssi_valid_i    (rssi_valid_i),
    .rssi_dbm_i      (rssi_dbm_i),
    .flow_count_i    (flow_count_i),
    .bit_rate_i      (bit_rate_i),
    .packet_rate_i   (packet_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .total_score_o   (total_score_o),
    .level_o         (level_o),
    .changed_o       (changed_o),
    .change_count_o  (change_count_o),
    .rtt_sub_o       (rtt_sub_o),
    .loss_sub_o      (loss_sub_o),
    .rssi_sub_o      (rssi_sub_o),
    .traffic_sub_o   (traffic_sub_o),
    .issue_bits_o    (issue_bits_o),
    .overall_issue_o (overall_issue_o)
  );

  // The sequencer is busy in the cycle after it takes an input beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_score_o <= SCORE_100)
    else $error("total score above 100 points");

  // Any overall issue means the total is under 50 points, which is level poor.
  a_issue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overall_issue_o != 2'd0 |-> level_o == 2'd0)
    else $error("overall issue reported with a level above poor");

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for link_quality_scorer: directed and random snapshots under
// several threshold settings, checked against an in-bench score predictor.
// Depends on lqs_pkg and the link_quality_scorer RTL.
`default_nettype none

module tb_top;
  import lqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] LVL_POOR = 2'd0, LVL_FAIR = 2'd1, LVL_GOOD = 2'd2, LVL_EXCEL = 2'd3;
  localparam logic [1:0] OVR_NONE = 2'd0, OVR_BELOW_AVG = 2'd1, OVR_POOR = 2'd2;
  localparam logic [3:0] ISS_LATENCY = 4'd1, ISS_LOSS = 4'd2, ISS_SIGNAL = 4'd4,
                         ISS_SMALL_PKT = 4'd8;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 330;

  typedef struct {
    logic        rtt_v;
    logic [23:0] rtt;
    logic        loss_v;
    logic [13:0] loss;
    logic        rssi_v;
    logic [7:0]  rssi;
    logic [15:0] flows;
    logic [31:0] bps;
    logic [31:0] pps;
  } snap_t;

  typedef struct {
    logic [14:0] total;
    logic [1:0]  level;
    logic        changed;
    logic [15:0] count;
    logic [14:0] rtt_sub, loss_sub, rssi_sub, trf_sub;
    logic [3:0]  issues;
    logic [1:0]  overall;
  } score_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic rtt_valid_i = 1'b0;
  logic [23:0] rtt_us_i = '0;
  logic loss_valid_i = 1'b0;
  logic [13:0] loss_rate_i = '0;
  logic rssi_valid_i = 1'b0;
  logic signed [7:0] rssi_dbm_i = '0;
  logic [15:0] flow_count_i = '0;
  logic [31:0] bit_rate_i = '0;
  logic [31:0] packet_rate_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [14:0] total_score_o, rtt_sub_o, loss_sub_o, rssi_sub_o, traffic_sub_o;
  logic [1:0] level_o, overall_issue_o;
  logic changed_o;
  logic [15:0] change_count_o;
  logic [3:0] issue_bits_o;

  link_quality_scorer dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Threshold copy and history state of the predictor.
  longint thr_rtt_ex, thr_rtt_gd, thr_rtt_fr, thr_loss_ex, thr_loss_gd, thr_loss_fr;
  longint thr_min_flows;
  logic [2:0] hist_level;
  logic [14:0] hist_score;
  logic [15:0] hist_changes;

  snap_t pend_q[$];
  score_t expect_q[$];
  int n_err = 0;
  int n_res = 0;

  function automatic void add_snap(snap_t s);
    pend_q = {pend_q, s};
  endfunction

  function automatic void add_expect(score_t r);
    expect_q = {expect_q, r};
  endfunction

  function automatic longint rdiv(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint ramp(longint v, longint lv, longint ls, longint rv, longint rs);
    if (rv <= lv || v <= lv) return ls;
    if (v >= rv) return rs;
    return ls + rdiv((rs - ls) * (v - lv), rv - lv);
  endfunction

  function automatic longint tiered(longint v, longint ex, longint gd, longint fr,
                                    longint tail, longint floor_sc);
    if (v <= ex) return SCORE_100;
    if (v <= gd) return ramp(v, ex, SCORE_100, gd, SCORE_80);
    if (v <= fr) return ramp(v, gd, SCORE_80, fr, SCORE_60);
    return ramp(v, fr, SCORE_60, fr + tail, floor_sc);
  endfunction

  function automatic longint signal_score(longint v);
    if (v >= RSSI_EXCELLENT_DBM) return SCORE_100;
    if (v >= RSSI_GOOD_DBM)
      return ramp(v, RSSI_GOOD_DBM, SCORE_80, RSSI_EXCELLENT_DBM, SCORE_100);
    if (v >= RSSI_FAIR_DBM)
      return ramp(v, RSSI_FAIR_DBM, SCORE_60, RSSI_GOOD_DBM, SCORE_80);
    return ramp(v, RSSI_FAIR_DBM - 25, SCORE_10, RSSI_FAIR_DBM, SCORE_60);
  endfunction

  function automatic longint traffic_score(longint f, longint bps, longint pps);
    longint m, n, r;
    m = (thr_min_flows == 0) ? 1 : thr_min_flows;
    n = bps - 200 * pps;
    if (f > m) f = m;
    if (n < 0) n = 0;
    if (n > 800 * pps) n = 800 * pps;
    r = SCORE_50 + rdiv(f * (32 * n - 50 * 256 * pps), m * pps);
    if (r < 0) r = 0;
    if (r > SCORE_100) r = SCORE_100;
    return r;
  endfunction

  // Scores one snapshot and advances the change history.
  function automatic score_t score_snapshot(snap_t s);
    score_t r;
    longint rs, ls, ss, ts, tot, rssi, diff;
    logic trf_ok;
    rssi = longint'($signed(s.rssi));
    trf_ok = s.flows != 0 && s.bps != 0 && s.pps != 0;
    rs = s.rtt_v ? tiered(s.rtt, thr_rtt_ex, thr_rtt_gd, thr_rtt_fr, RTT_TAIL_US, SCORE_20)
                 : SCORE_50;
    ls = s.loss_v ? tiered(s.loss, thr_loss_ex, thr_loss_gd, thr_loss_fr, LOSS_TAIL, SCORE_10)
                  : SCORE_50;
    ss = s.rssi_v ? signal_score(rssi) : SCORE_50;
    ts = trf_ok ? traffic_score(s.flows, s.bps, s.pps) : SCORE_50;
    tot = rdiv(3 * rs + 3 * ls + 2 * ss + 2 * ts, 10);
    if (tot >= SCORE_90) r.level = LVL_EXCEL;
    else if (tot >= SCORE_75) r.level = LVL_GOOD;
    else if (tot >= SCORE_50) r.level = LVL_FAIR;
    else r.level = LVL_POOR;
    r.issues = '0;
    if (s.rtt_v && s.rtt > thr_rtt_fr) r.issues |= ISS_LATENCY;
    if (s.loss_v && s.loss > thr_loss_fr) r.issues |= ISS_LOSS;
    if (s.rssi_v && rssi < RSSI_FAIR_DBM) r.issues |= ISS_SIGNAL;
    if (trf_ok && longint'(s.bps) < 200 * longint'(s.pps)) r.issues |= ISS_SMALL_PKT;
    if (tot < SCORE_30) r.overall = OVR_POOR;
    else if (tot < SCORE_50) r.overall = OVR_BELOW_AVG;
    else r.overall = OVR_NONE;
    diff = tot - longint'(hist_score);
    if (diff < 0) diff = -diff;
    r.changed = ({1'b0, r.level} != hist_level) || diff > SCORE_10;
    if (r.changed) hist_changes = hist_changes + 16'd1;
    hist_level = {1'b0, r.level};
    hist_score = tot[14:0];
    r.total = tot[14:0];
    r.count = hist_changes;
    r.rtt_sub = rs[14:0];
    r.loss_sub = ls[14:0];
    r.rssi_sub = ss[14:0];
    r.trf_sub = ts[14:0];
    return r;
  endfunction

  function automatic void set_threshold(cfg_idx_e idx, logic [23:0] d);
    case (idx)
      CFG_RTT_EXCELLENT:  thr_rtt_ex = d;
      CFG_RTT_GOOD:       thr_rtt_gd = d;
      CFG_RTT_FAIR:       thr_rtt_fr = d;
      CFG_LOSS_EXCELLENT: thr_loss_ex = d[13:0];
      CFG_LOSS_GOOD:      thr_loss_gd = d[13:0];
      CFG_LOSS_FAIR:      thr_loss_fr = d[13:0];
      CFG_MIN_FLOWS:      thr_min_flows = d[15:0];
      default: ;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  // The caller lowers cfg_valid_i after its last write.
  task automatic write_threshold(cfg_idx_e idx, logic [23:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    set_threshold(idx, d);
  endtask

  task automatic write_all(logic [23:0] re, rg, rf, le, lg, lf, mf);
    write_threshold(CFG_RTT_EXCELLENT, re);
    write_threshold(CFG_RTT_GOOD, rg);
    write_threshold(CFG_RTT_FAIR, rf);
    write_threshold(CFG_LOSS_EXCELLENT, le);
    write_threshold(CFG_LOSS_GOOD, lg);
    write_threshold(CFG_LOSS_FAIR, lf);
    write_threshold(CFG_MIN_FLOWS, mf);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic snap_t mk(logic rv, logic [23:0] rtt, logic lv, logic [13:0] loss,
                               logic sv, logic [7:0] rssi, logic [15:0] f,
                               logic [31:0] bps, logic [31:0] pps);
    snap_t s;
    s.rtt_v = rv; s.rtt = rtt; s.loss_v = lv; s.loss = loss;
    s.rssi_v = sv; s.rssi = rssi; s.flows = f; s.bps = bps; s.pps = pps;
    return s;
  endfunction

  // Mostly values near the thresholds and realistic rates; the rest full-range noise.
  function automatic snap_t rand_snap();
    snap_t s;
    longint k;
    s.rtt_v = $urandom_range(0, 9) != 0;
    s.loss_v = $urandom_range(0, 9) != 0;
    s.rssi_v = $urandom_range(0, 9) != 0;
    s.rtt = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 320000));
    s.loss = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000));
    if ($urandom_range(0, 7) == 0) s.rssi = 8'($urandom);
    else s.rssi = 8'(-int'($urandom_range(0, 128)));
    s.flows = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
    case ($urandom_range(0, 9))
      0: begin s.bps = $urandom; s.pps = $urandom; end
      1: begin s.bps = $urandom_range(0, 3); s.pps = $urandom_range(0, 3); end
      default: begin
        s.pps = $urandom_range(1, 3000000);
        k = longint'(s.pps) * $urandom_range(0, 1200) + $urandom_range(0, 1000);
        s.bps = k[31:0];
      end
    endcase
    return s;
  endfunction

  task automatic wait_idle();
    @(posedge clk_i);
    while (pend_q.size() != 0 || in_valid_i || expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    repeat (n) add_snap(rand_snap());
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  snap_t cur;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) add_expect(score_snapshot(cur));
    if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() != 0) begin
        cur = pend_q.pop_front();
        in_valid_i <= 1'b1;
        rtt_valid_i <= cur.rtt_v;
        rtt_us_i <= cur.rtt;
        loss_valid_i <= cur.loss_v;
        loss_rate_i <= cur.loss;
        rssi_valid_i <= cur.rssi_v;
        rssi_dbm_i <= cur.rssi;
        flow_count_i <= cur.flows;
        bit_rate_i <= cur.bps;
        packet_rate_i <= cur.pps;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: randomly re-chosen stall modes, plus one long hold-off.
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 3);
    if (!hold_done && n_res == 400) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0, 1: out_ready_i <= 1'b1;
        2: out_ready_i <= $urandom_range(0, 1) == 1;
        default: out_ready_i <= $urandom_range(0, 9) == 0;
      endcase
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      n_err++;
      if (n_err <= 10)
        $display("Mismatch on result %0d, %s: expected %0d, got %0d", n_res, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    score_t e;
    if (out_valid_o && out_ready_i) begin
      if (expect_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("Unexpected result beat, total %0d", total_score_o);
      end else begin
        e = expect_q.pop_front();
        check_field("total_score", e.total, total_score_o);
        check_field("level", e.level, level_o);
        check_field("changed", e.changed, changed_o);
        check_field("change_count", e.count, change_count_o);
        check_field("rtt_sub", e.rtt_sub, rtt_sub_o);
        check_field("loss_sub", e.loss_sub, loss_sub_o);
        check_field("rssi_sub", e.rssi_sub, rssi_sub_o);
        check_field("traffic_sub", e.trf_sub, traffic_sub_o);
        check_field("issue_bits", e.issues, issue_bits_o);
        check_field("overall_issue", e.overall, overall_issue_o);
      end
      n_res <= n_res + 1;
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    thr_rtt_ex = 50000; thr_rtt_gd = 100000; thr_rtt_fr = 200000;
    thr_loss_ex = 100; thr_loss_gd = 300; thr_loss_fr = 500;
    thr_min_flows = 10;
    hist_level = LEVEL_UNKNOWN;
    hist_score = '0;
    hist_changes = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds: anchors hit exactly, extremes, unavailable metrics, traffic corners.
    add_snap(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_snap(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_snap(mk(1, 0, 1, 0, 1, 8'd0, 16'hFFFF, 32'hFFFFFFFF, 1));
    add_snap(mk(1, 24'hFFFFFF, 1, 14'h3FFF, 1, 8'h80, 1, 1, 32'hFFFFFFFF));
    add_snap(mk(1, 50000, 1, 100, 1, -8'sd50, 10, 1000, 1));
    add_snap(mk(1, 100000, 1, 300, 1, -8'sd60, 10, 200, 1));
    add_snap(mk(1, 200000, 1, 500, 1, -8'sd70, 5, 600, 1));
    add_snap(mk(1, 280000, 1, 750, 1, -8'sd95, 3, 7777, 13));
    add_snap(mk(1, 150000, 1, 400, 1, -8'sd65, 9, 199, 1));
    add_snap(mk(1, 75000, 1, 200, 1, -8'sd55, 11, 1001, 1));
    add_snap(mk(1, 200001, 1, 501, 1, -8'sd71, 10, 500000, 1000));
    add_snap(mk(1, 280001, 1, 751, 1, 8'h7F, 0, 1000, 1));
    add_snap(mk(1, 24'h555555, 1, 14'h2AAA, 1, 8'h55, 16'h5555, 0, 32'h55555555));
    add_snap(mk(1, 24'hAAAAAA, 1, 14'h1555, 1, 8'hAA, 16'hAAAA, 32'hAAAAAAAA, 0));
    add_snap(mk(0, 24'hFFFFFF, 0, 14'h3FFF, 0, 8'h80, 16'hFFFF, 32'hFFFFFFFF,
                32'hFFFFFFFF));
    add_snap(mk(1, 60000, 0, 0, 1, -8'sd128, 2, 32'hFFFFFFFF, 32'h00FFFFFF));
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    write_all(24'($urandom_range(0, 80000)), 24'($urandom_range(80000, 150000)),
              24'($urandom_range(150000, 300000)), 24'($urandom_range(0, 200)),
              24'($urandom_range(200, 400)), 24'($urandom_range(400, 2000)),
              24'($urandom_range(1, 40)));
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    write_all(0, 0, 0, 0, 0, 0, 0);
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              24'hFFFFFF);
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    // Reversed anchors make the middle segments empty.
    write_all(300000, 100000, 50000, 900, 300, 100, 1);
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 24'($urandom));
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
